[src/vn4d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vn4d_pkg;

  // Field widths of the transfer payloads.
  localparam int unsigned CoordW = 24;
  localparam int unsigned ValueW = 16;
  localparam int unsigned PermW  = 8;
  localparam int unsigned IndexW = 8;
  localparam int unsigned CmdW   = 2;

  // Command codes carried by an input transfer.
  typedef enum logic [CmdW-1:0] {
    CMD_EVAL     = 2'd0,
    CMD_WR_VALUE = 2'd1,
    CMD_WR_PERM  = 2'd2
  } cmd_e;

endpackage

`default_nettype wire

[src/value_noise_4d.sv]
// Throughput: one item per cycle while no finished result is held back; the
// permutation and value lookups use replicated tables with two read ports per
// copy, and each blend level takes one multiply stage and one add stage.
// Reset: rst_ni clears the pipeline valid bits only; table contents are
// undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module value_noise_4d #(
  parameter int unsigned TABLE_SIZE = 256,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [vn4d_pkg::CmdW-1:0]             command_i,
  input  wire  [vn4d_pkg::CoordW-1:0]           x_coord_i,
  input  wire  [vn4d_pkg::CoordW-1:0]           y_coord_i,
  input  wire  [vn4d_pkg::CoordW-1:0]           z_coord_i,
  input  wire  [vn4d_pkg::CoordW-1:0]           t_coord_i,
  input  wire  [vn4d_pkg::IndexW-1:0]           entry_index_i,
  input  wire  signed [vn4d_pkg::ValueW-1:0]    value_entry_i,
  input  wire  [vn4d_pkg::PermW-1:0]            perm_entry_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [vn4d_pkg::ValueW-1:0]    noise_value_o
);
  import vn4d_pkg::*;

  localparam int unsigned IW     = $clog2(TABLE_SIZE);
  localparam int unsigned SW     = IW + PermW + 1;
  localparam int unsigned DW     = ValueW + 1;
  localparam int unsigned PW     = FRAC_BITS + 1 + DW;
  localparam int unsigned NStage = 13;

  typedef struct packed {
    logic [CmdW-1:0]             cmd;
    logic [3:0][IW-1:0]          ip;
    logic [3:0][FRAC_BITS-1:0]   fr;
    logic [IW-1:0]               widx;
    logic signed [ValueW-1:0]    wval;
    logic [PermW-1:0]            wperm;
  } item_t;

  // Table index of base + step + hash, wrapped to the table size.
  function automatic logic [IW-1:0] hidx(input logic [IW-1:0] b, input logic one,
                                         input logic [PermW-1:0] p);
    logic [SW-1:0] s;
    s = SW'(b) + SW'(one) + SW'(p);
    return s[IW-1:0];
  endfunction

  // A permutation entry used directly as a table index.
  function automatic logic [IW-1:0] pidx(input logic [PermW-1:0] p);
    logic [SW-1:0] s;
    s = SW'(p);
    return s[IW-1:0];
  endfunction

  // f * (b - a) for one blend.
  function automatic logic signed [PW-1:0] bprod(input logic signed [ValueW-1:0] a,
                                                 input logic signed [ValueW-1:0] b,
                                                 input logic [FRAC_BITS-1:0] f);
    logic signed [DW-1:0] d;
    d = DW'(b) - DW'(a);
    return PW'($signed({1'b0, f})) * PW'(d);
  endfunction

  // a + floor(product / 2^FRAC_BITS); the sum always stays in range.
  function automatic logic signed [ValueW-1:0] bsum(input logic signed [ValueW-1:0] a,
                                                    input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = p >>> FRAC_BITS;
    return a + q[ValueW-1:0];
  endfunction

  logic               en;
  logic [NStage:1]    vld_q;
  item_t              item_q [NStage:1];
  item_t              item_d;

  logic [PermW-1:0]   pt_q [2];
  logic [PermW-1:0]   pz_q [4];
  logic [PermW-1:0]   py_q [8];
  logic [PermW-1:0]   px_q [16];
  logic signed [ValueW-1:0] v_q [16];
  logic signed [PW-1:0]     p1_q [8];
  logic signed [ValueW-1:0] a1_q [8];
  logic signed [ValueW-1:0] r1_q [8];
  logic signed [PW-1:0]     p2_q [4];
  logic signed [ValueW-1:0] a2_q [4];
  logic signed [ValueW-1:0] r2_q [4];
  logic signed [PW-1:0]     p3_q [2];
  logic signed [ValueW-1:0] a3_q [2];
  logic signed [ValueW-1:0] r3_q [2];
  logic signed [PW-1:0]     p4_q;
  logic signed [ValueW-1:0] a4_q;
  logic signed [ValueW-1:0] res_q;

  // The whole pipeline advances unless a finished result is held back.
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NStage] && (item_q[NStage].cmd == CMD_EVAL);
  assign noise_value_o = res_q;

  // Split the incoming transfer into lattice and fraction parts.
  always_comb begin
    logic [CoordW-1:0] c [4];
    c[0] = x_coord_i;
    c[1] = y_coord_i;
    c[2] = z_coord_i;
    c[3] = t_coord_i;
    item_d.cmd   = command_i;
    for (int k = 0; k < 4; k++) begin
      logic [CoordW-1:0] sh;
      sh = c[k] >> FRAC_BITS;
      item_d.ip[k] = sh[IW-1:0];
      item_d.fr[k] = c[k][FRAC_BITS-1:0];
    end
    item_d.widx  = hidx('0, 1'b0, entry_index_i);
    item_d.wval  = value_entry_i;
    item_d.wperm = perm_entry_i;
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStage-1:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_q[1] <= item_d;
      for (int k = 2; k <= NStage; k++) begin
        item_q[k] <= item_q[k-1];
      end
    end
  end

  // First permutation level: one copy, read at t and t + 1.
  logic [PermW-1:0] perm1_mem [TABLE_SIZE];
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (in_valid_i && command_i == CMD_WR_PERM) begin
        perm1_mem[item_d.widx] <= item_d.wperm;
      end
      pt_q[0] <= perm1_mem[item_d.ip[3]];
      pt_q[1] <= perm1_mem[hidx(item_d.ip[3], 1'b1, '0)];
    end
  end

  // Second, third and fourth permutation levels and the value lookup. Each copy
  // is written when a write transfer passes the stage that reads it.
  for (genvar c = 0; c < 2; c++) begin : g_l2
    logic [PermW-1:0] mem [TABLE_SIZE];
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (vld_q[1] && item_q[1].cmd == CMD_WR_PERM) begin
          mem[item_q[1].widx] <= item_q[1].wperm;
        end
        pz_q[c*2]   <= mem[hidx(item_q[1].ip[2], 1'b0, pt_q[c])];
        pz_q[c*2+1] <= mem[hidx(item_q[1].ip[2], 1'b1, pt_q[c])];
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_l3
    logic [PermW-1:0] mem [TABLE_SIZE];
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (vld_q[2] && item_q[2].cmd == CMD_WR_PERM) begin
          mem[item_q[2].widx] <= item_q[2].wperm;
        end
        py_q[c*2]   <= mem[hidx(item_q[2].ip[1], 1'b0, pz_q[c])];
        py_q[c*2+1] <= mem[hidx(item_q[2].ip[1], 1'b1, pz_q[c])];
      end
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_l4
    logic [PermW-1:0] mem [TABLE_SIZE];
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (vld_q[3] && item_q[3].cmd == CMD_WR_PERM) begin
          mem[item_q[3].widx] <= item_q[3].wperm;
        end
        px_q[c*2]   <= mem[hidx(item_q[3].ip[0], 1'b0, py_q[c])];
        px_q[c*2+1] <= mem[hidx(item_q[3].ip[0], 1'b1, py_q[c])];
      end
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_val
    logic signed [ValueW-1:0] mem [TABLE_SIZE];
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (vld_q[4] && item_q[4].cmd == CMD_WR_VALUE) begin
          mem[item_q[4].widx] <= item_q[4].wval;
        end
        v_q[c*2]   <= mem[pidx(px_q[c*2])];
        v_q[c*2+1] <= mem[pidx(px_q[c*2+1])];
      end
    end
  end

  // Blend tree: each level multiplies in one stage and adds in the next.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int n = 0; n < 8; n++) begin
        p1_q[n] <= bprod(v_q[2*n], v_q[2*n+1], item_q[5].fr[0]);
        a1_q[n] <= v_q[2*n];
        r1_q[n] <= bsum(a1_q[n], p1_q[n]);
      end
      for (int n = 0; n < 4; n++) begin
        p2_q[n] <= bprod(r1_q[2*n], r1_q[2*n+1], item_q[7].fr[1]);
        a2_q[n] <= r1_q[2*n];
        r2_q[n] <= bsum(a2_q[n], p2_q[n]);
      end
      for (int n = 0; n < 2; n++) begin
        p3_q[n] <= bprod(r2_q[2*n], r2_q[2*n+1], item_q[9].fr[2]);
        a3_q[n] <= r2_q[2*n];
        r3_q[n] <= bsum(a3_q[n], p3_q[n]);
      end
      p4_q  <= bprod(r3_q[0], r3_q[1], item_q[11].fr[3]);
      a4_q  <= r3_q[0];
      res_q <= bsum(a4_q, p4_q);
    end
  end

endmodule

`default_nettype wire

[src/vn4d_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module vn4d_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_valid_i,
  input wire                                in_stall_o,
  input wire                                out_valid_o,
  input wire                                out_stall_i,
  input wire signed [vn4d_pkg::ValueW-1:0]  noise_value_o
);
  import vn4d_pkg::*;

  // A held result stays put until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(noise_value_o))
    else $error("held result changed");

  // The input side only stalls behind a blocked result.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A stalled input transfer is still offered in the next cycle.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i)
    else $error("stalled input transfer withdrawn");

endmodule

bind value_noise_4d vn4d_checker u_vn4d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .noise_value_o (noise_value_o)
);

`default_nettype wire
